FILE: hw/rtl/lpr_session_classifier_core_assert.svh
// assertion macros for the line-printer session classifier
`ifndef LPR_SESSION_CLASSIFIER_CORE_ASSERT_SVH
`define LPR_SESSION_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define LPRSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LPRSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/lprsc_pkg.sv
// types and codes shared by the line-printer session classifier
package lprsc_pkg;

   localparam logic [2:0] PH_COMMAND = 3'd0;
   localparam logic [2:0] PH_RECEIVE = 3'd1;
   localparam logic [2:0] PH_REPLY1  = 3'd2;
   localparam logic [2:0] PH_REPLY   = 3'd3;
   localparam logic [2:0] PH_IGNORE  = 3'd4;

   localparam logic [1:0] V_INPROC   = 2'd0;
   localparam logic [1:0] V_FOUND    = 2'd1;
   localparam logic [1:0] V_NOMATCH  = 2'd2;
   localparam logic [1:0] V_INCOMPAT = 2'd3;

   localparam logic [3:0] THRESHOLD_RESET = 4'd2;

   typedef struct packed {
      logic       empty_packet;
      logic       last_byte;
      logic       first_byte;
      logic [7:0] data_byte;
      logic       from_initiator;
      logic [7:0] flow_id;
   } item_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [3:0] count;
   } entry_type;

   typedef struct packed {
      logic [15:0] position;
      logic [7:0]  lead;
      logic [1:0]  field;
      logic        bad;
   } pkt_state_type;

   typedef struct packed {
      logic       has_result;
      logic       write;
      logic [1:0] verdict;
   } eval_out_type;

endpackage

FILE: hw/rtl/lprsc_session_eval.sv
// per-byte syntax checks and verdict / phase update for one request
module lprsc_session_eval (
   input  lprsc_pkg::item_type      item,
   input  lprsc_pkg::entry_type     entry,
   input  lprsc_pkg::pkt_state_type pkt,
   input  logic [3:0]               threshold,
   output lprsc_pkg::entry_type     entry_next,
   output lprsc_pkg::pkt_state_type pkt_next,
   output lprsc_pkg::eval_out_type  result
);
   import lprsc_pkg::*;

   localparam logic [7:0] LF = 8'h0A;
   localparam logic [7:0] CMD_PRINT   = 8'd1;
   localparam logic [7:0] CMD_RECEIVE = 8'd2;
   localparam logic [7:0] CMD_QUEUE   = 8'd3;
   localparam logic [7:0] CMD_REMOVE  = 8'd5;
   localparam logic [7:0] SUB_ABORT   = 8'd1;
   localparam logic [7:0] SUB_CONTROL = 8'd2;
   localparam logic [7:0] SUB_DATA    = 8'd3;
   localparam logic [1:0] FP_START  = 2'd0;
   localparam logic [1:0] FP_DIGITS = 2'd1;
   localparam logic [1:0] FP_NAME   = 2'd2;
   localparam logic [15:0] POS_MAX  = 16'hFFFF;

   function automatic logic is_graph(input logic [7:0] b);
      return (b >= 8'h21) && (b <= 8'h7E);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
   endfunction

   logic [15:0] pos;
   logic [3:0]  count_sat;
   logic [7:0]  b;

   always_comb begin
      b          = item.data_byte;
      pos        = item.first_byte ? 16'd0 : pkt.position;
      count_sat  = (entry.count != 4'hF) ? entry.count + 4'd1 : 4'hF;
      pkt_next   = pkt;
      entry_next = entry;
      result.has_result = item.empty_packet | item.last_byte;
      result.write      = 1'b0;
      result.verdict    = V_INCOMPAT;
      if (item.empty_packet) begin
         result.verdict = V_INPROC;
      end else begin
         pkt_next.position = (pos != POS_MAX) ? pos + 16'd1 : POS_MAX;
         if (pos == 16'd0) begin
            pkt_next.lead  = b;
            pkt_next.field = FP_START;
            pkt_next.bad   = 1'b0;
         end else if (!item.last_byte) begin
            // inner byte checks
            if (entry.phase == PH_COMMAND) begin
               if (pkt.lead == CMD_RECEIVE && !is_graph(b)) begin
                  pkt_next.bad = 1'b1;
               end
            end else if (entry.phase == PH_RECEIVE) begin
               if (pkt.lead == SUB_ABORT) begin
                  pkt_next.bad = 1'b1;
               end else if (pkt.lead == SUB_CONTROL || pkt.lead == SUB_DATA) begin
                  if (pkt.field == FP_START) begin
                     if (is_digit(b)) begin
                        pkt_next.field = FP_DIGITS;
                     end else begin
                        pkt_next.bad = 1'b1;
                     end
                  end else if (pkt.field == FP_DIGITS) begin
                     if (b == LF) begin
                        pkt_next.bad = 1'b1;
                     end else if (is_ws(b)) begin
                        pkt_next.field = FP_NAME;
                     end else if (!is_digit(b)) begin
                        pkt_next.bad = 1'b1;
                     end
                  end else begin
                     if (!is_graph(b)) begin
                        pkt_next.bad = 1'b1;
                     end
                  end
               end
            end
         end
         if (item.last_byte) begin
            result.write = 1'b1;
            unique case (entry.phase)
               PH_COMMAND: begin
                  if (item.from_initiator && pos >= 16'd2) begin
                     if (pkt_next.lead == CMD_RECEIVE) begin
                        if (!pkt_next.bad && b == LF) begin
                           entry_next.phase = PH_REPLY;
                           result.verdict   = V_INPROC;
                        end
                     end else if (pkt_next.lead == CMD_PRINT ||
                                  (pkt_next.lead >= CMD_QUEUE &&
                                   pkt_next.lead <= CMD_REMOVE)) begin
                        entry_next.phase = PH_IGNORE;
                        result.verdict   = V_INPROC;
                     end
                  end
               end
               PH_RECEIVE: begin
                  if (!item.from_initiator) begin
                     result.verdict = V_INPROC;
                  end else if (pkt_next.lead == SUB_ABORT) begin
                     if (pos == 16'd1 && b == LF) begin
                        entry_next.phase = PH_REPLY;
                        result.verdict   = V_INPROC;
                     end
                  end else if (pkt_next.lead == SUB_CONTROL ||
                               pkt_next.lead == SUB_DATA) begin
                     if (pos >= 16'd4 && b == LF && !pkt_next.bad &&
                         pkt_next.field == FP_NAME) begin
                        entry_next.phase = PH_REPLY1;
                        result.verdict   = V_INPROC;
                     end
                  end
               end
               PH_REPLY1, PH_REPLY: begin
                  if (item.from_initiator) begin
                     result.verdict = V_INPROC;
                  end else if (pos != 16'd0) begin
                     result.verdict = V_NOMATCH;
                  end else begin
                     entry_next.count = count_sat;
                     if (count_sat >= threshold) begin
                        entry_next.phase = PH_IGNORE;
                        result.verdict   = V_FOUND;
                     end else begin
                        entry_next.phase = (entry.phase == PH_REPLY1) ? PH_REPLY
                                                                      : PH_RECEIVE;
                        result.verdict   = V_INPROC;
                     end
                  end
               end
               PH_IGNORE: begin
                  result.verdict = V_INPROC;
               end
               default: begin
                  result.verdict = V_INCOMPAT;
               end
            endcase
         end
      end
   end

endmodule

FILE: hw/rtl/lpr_session_classifier_core.sv
// line-printer session classifier top level
//
// requests arrive on req_* one payload byte each, tagged with flow, direction,
// first/last marks (first and direction and empty in req_tuser, last in
// req_tlast). a verdict is returned on rsp_* for each last byte and for each
// empty packet; other bytes give no response.
// the per-flow phase and reply count sit in a one-port-read, one-port-write
// memory with a registered read port; a valid bit per entry makes an entry
// never written read as command phase with zero count.
// a request is read from memory at the accept edge, then evaluated and written
// back when the evaluate stage moves on; a write that lands at the same edge
// as the next read of that entry is forwarded.
// throughput: one request per cycle while no verdict waits on a full output.
// rsp_tvalid is registered, set as the evaluate stage passes on its verdict.
// when rsp_tready is low the held verdict stays in the output register; bytes
// without a verdict keep flowing, the next request with a verdict waits in the
// evaluate stage and req_tready drops.
// reset (synchronous) clears all valid bits, the packet state and sets the
// reply threshold to two; no clearing pass is needed.
// csr_wr_en writes the reply threshold; write it only while idle.
module lpr_session_classifier_core #(
   parameter int FLOW_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // flow_id, data_byte
   input  logic [2:0]  req_tuser,  // from_initiator, first_byte, empty_packet
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // verdict, verdict_flow, zero fill
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);
   import lprsc_pkg::*;

   localparam int DEPTH   = (FLOW_COUNT < 256) ? FLOW_COUNT : 256;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [256*IDX_W-1:0] build_flow_map();
      logic [256*IDX_W-1:0] map;
      map = '0;
      for (int i = 0; i < 256; i++) begin
         map[i*IDX_W +: IDX_W] = IDX_W'(i % DEPTH);
      end
      return map;
   endfunction

   localparam logic [256*IDX_W-1:0] FLOW_MAP = build_flow_map();

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic [DEPTH-1:0]   valid_ff;

   item_type      req_item;
   logic [IDX_W-1:0] req_idx;
   logic          req_fire;

   logic          s1_valid_ff;
   item_type      s1_item_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic          fwd_hit_ff;
   entry_type     fwd_entry_ff;
   pkt_state_type pkt_ff;
   logic [3:0]    threshold_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_verdict_ff;
   logic [7:0]    rsp_flow_ff;

   entry_type     s1_entry;
   entry_type     entry_in;
   pkt_state_type pkt_in;
   eval_out_type  eval;
   logic          out_free;
   logic          s1_fire;
   logic          wr_en;

   assign req_item.flow_id        = req_tdata[7:0];
   assign req_item.data_byte      = req_tdata[15:8];
   assign req_item.from_initiator = req_tuser[0];
   assign req_item.first_byte     = req_tuser[1];
   assign req_item.empty_packet   = req_tuser[2];
   assign req_item.last_byte      = req_tlast;
   assign req_idx = FLOW_MAP[req_item.flow_id*IDX_W +: IDX_W];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && (!eval.has_result || out_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign wr_en      = s1_fire && eval.write;

   always_comb begin
      if (fwd_hit_ff) begin
         s1_entry = fwd_entry_ff;
      end else if (valid_ff[s1_idx_ff]) begin
         s1_entry = entry_type'(rd_ff);
      end else begin
         s1_entry = '0;
      end
   end

   lprsc_session_eval u_eval (
      .item       (s1_item_ff),
      .entry      (s1_entry),
      .pkt        (pkt_ff),
      .threshold  (threshold_ff),
      .entry_next (entry_in),
      .pkt_next   (pkt_in),
      .result     (eval)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_idx_ff] <= ENTRY_W'(entry_in);
      end
      if (req_fire) begin
         rd_ff <= mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         pkt_ff       <= '0;
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[s1_idx_ff] <= 1'b1;
         end
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         if (s1_fire) begin
            pkt_ff <= pkt_in;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            fwd_hit_ff  <= wr_en && (s1_idx_ff == req_idx);
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
            fwd_hit_ff  <= 1'b0;
         end
         if (s1_fire && eval.has_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff   <= req_item;
         s1_idx_ff    <= req_idx;
         fwd_entry_ff <= entry_in;
      end
      if (s1_fire && eval.has_result) begin
         rsp_verdict_ff <= eval.verdict;
         rsp_flow_ff    <= s1_item_ff.flow_id;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_flow_ff, rsp_verdict_ff};

`include "lpr_session_classifier_core_assert.svh"

   `LPRSC_ASSERT_NOW(a_fwd_needs_item, clock, reset, fwd_hit_ff, s1_valid_ff, "forward without item")
   `LPRSC_ASSERT_NEXT(a_accept_loads, clock, reset, req_tvalid && req_tready, s1_valid_ff, "accepted request lost")
   `LPRSC_ASSERT_NEXT(a_result_shown, clock, reset, s1_fire && eval.has_result, rsp_tvalid, "verdict not presented")
   `LPRSC_ASSERT_NEXT(a_csr_write, clock, reset, csr_wr_en, threshold_ff == $past(csr_wr_data), "threshold write lost")

endmodule

FILE: dv/tb_lpr_session_classifier_core.sv
// self-checking testbench for the line-printer session classifier core
module tb_lpr_session_classifier_core;
   timeunit 1ns;
   timeprecision 1ps;

   import lprsc_pkg::*;

   localparam int FLOWS = 256;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 170;
   localparam int LONG_BODY = 40;

   localparam logic [7:0] LF = 8'h0A;
   localparam logic [7:0] SPACE = 8'h20;

   // command codes in command phase
   localparam logic [7:0] OP_PRINT = 8'd1;
   localparam logic [7:0] OP_RECEIVE = 8'd2;
   localparam logic [7:0] OP_REMOVE = 8'd5;
   // subcommand codes in receive phase
   localparam logic [7:0] SUB_ABORT = 8'd1;
   localparam logic [7:0] SUB_CONTROL = 8'd2;
   localparam logic [7:0] SUB_DATA = 8'd3;

   localparam logic [1:0] FIELD_JOB = 2'd0;
   localparam logic [1:0] FIELD_DIGITS = 2'd1;
   localparam logic [1:0] FIELD_NAME = 2'd2;

   typedef struct packed {
      logic [1:0] verdict;
      logic [7:0] flow;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // flow_id, data_byte
   logic [2:0]  req_tuser = '0;   // from_initiator, first_byte, empty_packet
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // verdict, verdict_flow, zero fill
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   lpr_session_classifier_core #(.FLOW_COUNT(FLOWS)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // classifier state mirror
   logic [2:0]  sess_phase [FLOWS];
   logic [3:0]  sess_replies [FLOWS];
   logic [15:0] pkt_pos = '0;
   logic [7:0]  pkt_lead = '0;
   logic [1:0]  pkt_field = FIELD_JOB;
   logic        pkt_bad = 1'b0;
   logic [3:0]  reply_limit = THRESHOLD_RESET;

   item_type    pending_requests [$];
   verdict_type expected_verdicts [$];
   logic [7:0]  payload [$];
   item_type    req_item = '0;

   int gap_mode = 1;
   int req_gap = 0;
   int rsp_stall = 0;
   int requests_pushed = 0;
   int requests_accepted = 0;
   int verdicts_predicted = 0;
   int verdicts_checked = 0;
   int fault_count = 0;
   int quiet_cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit is_graph(logic [7:0] b);
      return b >= 8'h21 && b <= 8'h7E;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic bit is_space(logic [7:0] b);
      return (b >= 8'h09 && b <= 8'h0D) || b == SPACE;
   endfunction

   function automatic logic [7:0] rand_graph();
      return 8'($urandom_range(8'h7E, 8'h21));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (gap_mode == 0 || r < 65) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 8);
   endfunction

   // updates the mirror for one request, queues a verdict when one is due
   function automatic bit classify_request(item_type it);
      logic [15:0] pos;
      logic [2:0]  ph;
      logic [1:0]  v;
      logic [7:0]  b;
      logic [7:0]  fl;
      verdict_type rec;
      b = it.data_byte;
      fl = it.flow_id;
      rec.flow = fl;
      if (it.empty_packet) begin
         rec.verdict = V_INPROC;
         expected_verdicts.push_back(rec);
         return 1'b1;
      end
      pos = it.first_byte ? 16'd0 : pkt_pos;
      pkt_pos = (pos == 16'hFFFF) ? pos : pos + 16'd1;
      ph = sess_phase[fl];
      if (pos == 16'd0) begin
         pkt_lead = b;
         pkt_field = FIELD_JOB;
         pkt_bad = 1'b0;
      end else if (!it.last_byte) begin
         if (ph == PH_COMMAND) begin
            if (pkt_lead == OP_RECEIVE && !is_graph(b)) pkt_bad = 1'b1;
         end else if (ph == PH_RECEIVE) begin
            if (pkt_lead == SUB_ABORT) begin
               pkt_bad = 1'b1;
            end else if (pkt_lead == SUB_CONTROL || pkt_lead == SUB_DATA) begin
               case (pkt_field)
                  FIELD_JOB: begin
                     if (is_digit(b)) pkt_field = FIELD_DIGITS;
                     else pkt_bad = 1'b1;
                  end
                  FIELD_DIGITS: begin
                     if (b == LF) pkt_bad = 1'b1;
                     else if (is_space(b)) pkt_field = FIELD_NAME;
                     else if (!is_digit(b)) pkt_bad = 1'b1;
                  end
                  default: begin
                     if (!is_graph(b)) pkt_bad = 1'b1;
                  end
               endcase
            end
         end
      end
      if (!it.last_byte) return 1'b0;

      v = V_INCOMPAT;
      case (ph)
         PH_COMMAND: begin
            if (it.from_initiator && pos >= 16'd2) begin
               if (pkt_lead == OP_RECEIVE) begin
                  if (!pkt_bad && b == LF) begin
                     sess_phase[fl] = PH_REPLY;
                     v = V_INPROC;
                  end
               end else if (pkt_lead == OP_PRINT ||
                            (pkt_lead > OP_RECEIVE && pkt_lead <= OP_REMOVE)) begin
                  sess_phase[fl] = PH_IGNORE;
                  v = V_INPROC;
               end
            end
         end
         PH_RECEIVE: begin
            if (!it.from_initiator) begin
               v = V_INPROC;
            end else if (pkt_lead == SUB_ABORT) begin
               if (pos == 16'd1 && b == LF) begin
                  sess_phase[fl] = PH_REPLY;
                  v = V_INPROC;
               end
            end else if (pkt_lead == SUB_CONTROL || pkt_lead == SUB_DATA) begin
               if (pos >= 16'd4 && b == LF && !pkt_bad && pkt_field == FIELD_NAME) begin
                  sess_phase[fl] = PH_REPLY1;
                  v = V_INPROC;
               end
            end
         end
         PH_REPLY1, PH_REPLY: begin
            if (it.from_initiator) begin
               v = V_INPROC;
            end else if (pos != 16'd0) begin
               v = V_NOMATCH;
            end else begin
               if (sess_replies[fl] != 4'hF) sess_replies[fl] = sess_replies[fl] + 4'd1;
               if (sess_replies[fl] >= reply_limit) begin
                  sess_phase[fl] = PH_IGNORE;
                  v = V_FOUND;
               end else begin
                  sess_phase[fl] = (ph == PH_REPLY1) ? PH_REPLY : PH_RECEIVE;
                  v = V_INPROC;
               end
            end
         end
         PH_IGNORE: v = V_INPROC;
         default: v = V_INCOMPAT;
      endcase
      rec.verdict = v;
      expected_verdicts.push_back(rec);
      return 1'b1;
   endfunction

   // request driver
   always @(posedge clock) begin : driver
      item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            requests_accepted <= requests_accepted + 1;
            if (classify_request(req_item)) verdicts_predicted <= verdicts_predicted + 1;
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            nxt = pending_requests.pop_front();
            req_item <= nxt;
            req_tdata <= {nxt.data_byte, nxt.flow_id};
            req_tuser <= {nxt.empty_packet, nxt.first_byte, nxt.from_initiator};
            req_tlast <= nxt.last_byte;
            req_tvalid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // verdict monitor
   always @(posedge clock) begin : monitor
      verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            verdicts_checked <= verdicts_checked + 1;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected verdict, expected none, actual %h", $time, rsp_tdata);
               fault_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tdata[1:0] !== want.verdict) begin
                  $display("%0t: verdict mismatch, expected %0d, actual %0d",
                           $time, want.verdict, rsp_tdata[1:0]);
                  fault_count++;
               end
               if (rsp_tdata[9:2] !== want.flow) begin
                  $display("%0t: verdict_flow mismatch, expected %0d, actual %0d",
                           $time, want.flow, rsp_tdata[9:2]);
                  fault_count++;
               end
               if (rsp_tdata[15:10] !== 6'd0) begin
                  $display("%0t: fill mismatch, expected 0, actual %h",
                           $time, rsp_tdata[15:10]);
                  fault_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_lpr_session_classifier_core NOT OK");
         $finish;
      end
   end

   task automatic push_request(input logic [7:0] flow, input logic init, input logic [7:0] b,
                               input logic first, input logic last, input logic empty);
      item_type it;
      it.flow_id = flow;
      it.from_initiator = init;
      it.data_byte = b;
      it.first_byte = first;
      it.last_byte = last;
      it.empty_packet = empty;
      pending_requests.push_back(it);
      requests_pushed++;
   endtask

   task automatic send_payload(input logic [7:0] flow, input logic init);
      foreach (payload[i]) begin
         push_request(flow, init, payload[i], i == 0, i == payload.size() - 1, 1'b0);
      end
   endtask

   task automatic build_command();
      int r;
      int n;
      r = $urandom_range(9, 0);
      n = $urandom_range(6, 0);
      if (r < 6) payload = {OP_RECEIVE};
      else if (r < 9) payload = {8'($urandom_range(OP_REMOVE, OP_PRINT))};
      else payload = {8'($urandom)};
      repeat (n) payload.push_back(rand_graph());
      if (n > 0 && $urandom_range(7, 0) == 0) payload[$urandom_range(n, 1)] = 8'($urandom);
      payload.push_back(($urandom_range(9, 0) == 0) ? 8'($urandom) : LF);
   endtask

   task automatic build_subcommand();
      int r;
      int n;
      r = $urandom_range(9, 0);
      if (r == 0) begin
         payload = {SUB_ABORT, LF};
      end else if (r == 1) begin
         payload = {SUB_ABORT, rand_graph(), LF};
      end else begin
         if (r < 9) payload = {($urandom_range(1, 0) == 1) ? SUB_CONTROL : SUB_DATA};
         else payload = {8'($urandom)};
         n = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(3, 1);
         repeat (n) payload.push_back(8'($urandom_range(8'h39, 8'h30)));
         payload.push_back(($urandom_range(4, 0) != 0) ? SPACE : 8'($urandom_range(13, 9)));
         repeat ($urandom_range(5, 1)) payload.push_back(rand_graph());
         if ($urandom_range(7, 0) == 0) payload[$urandom_range(payload.size() - 1, 1)] = 8'($urandom);
         payload.push_back(LF);
      end
   endtask

   task automatic build_reply();
      int r;
      r = $urandom_range(5, 0);
      if (r < 4) payload = {8'h00};
      else if (r == 4) payload = {8'($urandom)};
      else begin
         payload = {};
         repeat ($urandom_range(4, 2)) payload.push_back(8'($urandom));
      end
   endtask

   task automatic run_session();
      logic [7:0] flow;
      int c;
      flow = 8'($urandom);
      build_command();
      send_payload(flow, $urandom_range(9, 0) != 0);
      repeat ($urandom_range(10, 2)) begin
         c = $urandom_range(9, 0);
         if (c < 4) begin
            build_reply();
            send_payload(flow, 1'b0);
         end else if (c < 8) begin
            build_subcommand();
            send_payload(flow, $urandom_range(9, 0) != 0);
         end else if (c == 8) begin
            push_request(flow, 1'($urandom_range(1, 0)), 8'($urandom),
                         1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), 1'b1);
         end else begin
            payload = {8'($urandom)};
            send_payload(flow, 1'b1);
         end
      end
   endtask

   task automatic add_noise();
      repeat ($urandom_range(6, 1)) begin
         push_request(8'($urandom), 1'($urandom_range(1, 0)), 8'($urandom),
                      1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                      $urandom_range(7, 0) == 0);
      end
   endtask

   task automatic add_random_traffic(input int count);
      int target;
      target = requests_pushed + count;
      while (requests_pushed < target) begin
         if ($urandom_range(7, 0) == 0) add_noise();
         else run_session();
      end
   endtask

   task automatic wait_idle();
      while (requests_accepted != requests_pushed || verdicts_predicted > verdicts_checked) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic program_threshold(input logic [3:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      reply_limit = value;
   endtask

   initial begin
      foreach (sess_phase[i]) begin
         sess_phase[i] = PH_COMMAND;
         sess_replies[i] = 4'd0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      gap_mode = 1;
      push_request(8'd0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1);
      // full session on the top flow up to service found
      payload = {OP_RECEIVE, "q", LF};
      send_payload(8'd255, 1'b1);
      push_request(8'd255, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0);
      payload = {SUB_CONTROL, "7", SPACE, "f", LF};
      send_payload(8'd255, 1'b1);
      push_request(8'd255, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b0);
      push_request(8'd255, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0);
      payload = {OP_REMOVE, "x", LF};
      send_payload(8'd0, 1'b1);
      // no first mark, position keeps counting
      push_request(8'd1, 1'b1, OP_RECEIVE, 1'b0, 1'b0, 1'b0);
      push_request(8'd1, 1'b1, LF, 1'b0, 1'b1, 1'b0);
      // flows and directions mixed inside one packet
      push_request(8'd2, 1'b1, OP_RECEIVE, 1'b1, 1'b0, 1'b0);
      push_request(8'd3, 1'b0, "a", 1'b0, 1'b0, 1'b0);
      push_request(8'd2, 1'b1, LF, 1'b0, 1'b1, 1'b0);
      payload = {OP_RECEIVE, LF};
      send_payload(8'd4, 1'b1);
      add_random_traffic(PHASE_ITEMS);
      wait_idle();

      program_threshold(4'd15);
      gap_mode = 0;
      add_random_traffic(PHASE_ITEMS);
      wait_idle();

      program_threshold(4'd1);
      gap_mode = 1;
      add_random_traffic(PHASE_ITEMS);
      wait_idle();

      program_threshold(4'($urandom_range(15, 1)));
      add_random_traffic(PHASE_ITEMS);
      wait_idle();

      // long command line back to back
      program_threshold(THRESHOLD_RESET);
      gap_mode = 0;
      payload = {OP_RECEIVE};
      repeat (LONG_BODY) payload.push_back(rand_graph());
      payload.push_back(LF);
      send_payload(8'($urandom), 1'b1);
      add_random_traffic(30);
      wait_idle();

      repeat (10) @(posedge clock);
      if (fault_count == 0 && expected_verdicts.size() == 0) begin
         $display("tb_lpr_session_classifier_core OK");
      end else begin
         $display("tb_lpr_session_classifier_core NOT OK");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/lprsc_pkg.sv
hw/rtl/lprsc_session_eval.sv
hw/rtl/lpr_session_classifier_core.sv
dv/tb_lpr_session_classifier_core.sv
